// File: hdl/round_robin_run_queue_defines.svh
// Assertion macros for the round-robin run queue.
`ifndef ROUND_ROBIN_RUN_QUEUE_DEFINES_SVH
`define ROUND_ROBIN_RUN_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define RRQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("run queue assertion failed");
`define RRQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("run queue assertion failed");
`else
`define RRQ_ASSERT_SAME(label, ante, cons)
`define RRQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hdl/rrq_pkg.sv
// Types, request codes and helpers used by the run queue module.
`default_nettype none

package rrq_pkg;

    localparam int unsigned HANDLE_W  = 16;
    localparam int unsigned HART_W    = 3;
    localparam int unsigned CNT_OUT_W = 10;
    localparam int unsigned NUM_HARTS = 8;

    localparam logic [1:0] REQ_ENQUEUE = 2'd0;
    localparam logic [1:0] REQ_DEQUEUE = 2'd1;
    localparam logic [1:0] REQ_REMOVE  = 2'd2;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [HANDLE_W-1:0] proc_handle;
        logic [HART_W-1:0]   hart_id;
    } rrq_req_t;

    typedef struct packed {
        logic [HANDLE_W-1:0]  proc_out;
        logic                 is_idle;
        logic                 full_error;
        logic [CNT_OUT_W-1:0] removed_count;
        logic [CNT_OUT_W-1:0] queue_count;
    } rrq_rsp_t;

    function automatic logic [HANDLE_W-1:0] idle_handle(input logic [HART_W-1:0] hart);
        logic [HART_W-1:0] v;
        v = hart;
        for (int i = 0; i < 8; i++) begin
            if (v >= NUM_HARTS) begin
                v = v - HART_W'(NUM_HARTS);
            end
        end
        return {{(HANDLE_W-HART_W){1'b0}}, v};
    endfunction

endpackage

`default_nettype wire

// File: hdl/rrq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module rrq_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: hdl/round_robin_run_queue.sv
// Run queue of process handles kept in a ring buffer RAM, with enqueue, dequeue and remove.
//
//   Channel   Ports             Direction  Payload
//   request   s_valid/s_ready   in         rrq_req_t (type, handle, hart)
//   result    m_valid/m_ready   out        rrq_rsp_t (handle, flags, counts)
//
// Enqueue and dequeue make one RAM read or setup step, then the commit.
// Remove walks the ring through the single RAM read port, one entry a cycle,
// compacting kept entries through the write port, then commits.
// Reset empties the queue at once; the RAM needs no clearing pass.
// A new request is taken while the previous result waits on m_ready; the commit
// of that request waits until the result register is free.
`default_nettype none
`include "round_robin_run_queue_defines.svh"

module round_robin_run_queue #(
    parameter int unsigned QUEUE_DEPTH = 512
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output      logic             s_ready,
    input  wire rrq_pkg::rrq_req_t s_data,
    output      logic             m_valid,
    input  wire logic             m_ready,
    output      rrq_pkg::rrq_rsp_t m_data
);

    import rrq_pkg::*;

    localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] s);
        if (s == IDX_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return s + 1'b1;
    endfunction

    function automatic logic [CNT_OUT_W-1:0] cnt_out(input logic [CNT_W-1:0] c);
        logic [CNT_W+CNT_OUT_W-1:0] ext;
        ext = {{CNT_OUT_W{1'b0}}, c};
        return ext[CNT_OUT_W-1:0];
    endfunction

    logic [1:0]       state_reg, state_next;
    rrq_req_t         req_reg;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] chk_reg, chk_next;
    logic [CNT_W-1:0] kept_reg, kept_next;
    logic [CNT_W-1:0] rmv_reg, rmv_next;
    logic [IDX_W-1:0] rd_slot_reg, rd_slot_next;
    logic [IDX_W-1:0] wr_slot_reg, wr_slot_next;
    logic             m_valid_reg, m_valid_next;
    rrq_rsp_t         m_data_reg, m_data_next;

    logic              accept;
    logic              out_free;
    logic              commit;
    logic              walk_live;
    logic              hit;
    logic              full;
    logic [IDX_W:0]    tail_sum;
    logic [IDX_W-1:0]  tail_slot;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [HANDLE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [HANDLE_W-1:0] ram_rdata;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign commit    = (state_reg == ST_FIN) && out_free;
    assign walk_live = (state_reg == ST_WALK) && (chk_reg != count_reg);
    assign hit       = (ram_rdata == req_reg.proc_handle);
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));

    assign tail_sum  = {1'b0, head_reg} + {1'b0, count_reg[IDX_W-1:0]};
    assign tail_slot = (tail_sum >= (IDX_W+1)'(QUEUE_DEPTH))
                     ? IDX_W'(tail_sum - (IDX_W+1)'(QUEUE_DEPTH))
                     : tail_sum[IDX_W-1:0];

    assign ram_re    = accept || (state_reg == ST_WALK);
    assign ram_raddr = (state_reg == ST_IDLE) ? head_reg : rd_slot_reg;
    assign ram_we    = (walk_live && !hit)
                     || (commit && (req_reg.req_type == REQ_ENQUEUE) && !full);
    assign ram_waddr = (state_reg == ST_WALK) ? wr_slot_reg : tail_slot;
    assign ram_wdata = (state_reg == ST_WALK) ? ram_rdata : req_reg.proc_handle;

    rrq_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        chk_next     = chk_reg;
        kept_next    = kept_reg;
        rmv_next     = rmv_reg;
        rd_slot_next = rd_slot_reg;
        wr_slot_next = wr_slot_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next   = (s_data.req_type == REQ_REMOVE) ? ST_WALK : ST_FIN;
                    chk_next     = '0;
                    kept_next    = '0;
                    rmv_next     = '0;
                    rd_slot_next = slot_inc(head_reg);
                    wr_slot_next = head_reg;
                end
            end
            ST_WALK: begin
                if (chk_reg == count_reg) begin
                    state_next = ST_FIN;
                end else begin
                    chk_next     = chk_reg + 1'b1;
                    rd_slot_next = slot_inc(rd_slot_reg);
                    if (hit) begin
                        rmv_next = rmv_reg + 1'b1;
                    end else begin
                        kept_next    = kept_reg + 1'b1;
                        wr_slot_next = slot_inc(wr_slot_reg);
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    unique case (req_reg.req_type)
                        REQ_ENQUEUE: begin
                            if (full) begin
                                m_data_next.full_error = 1'b1;
                            end else begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        REQ_DEQUEUE: begin
                            if (count_reg == '0) begin
                                m_data_next.proc_out = idle_handle(req_reg.hart_id);
                                m_data_next.is_idle  = 1'b1;
                            end else begin
                                m_data_next.proc_out = ram_rdata;
                                head_next            = slot_inc(head_reg);
                                count_next           = count_reg - 1'b1;
                            end
                        end
                        REQ_REMOVE: begin
                            count_next                = kept_reg;
                            m_data_next.removed_count = cnt_out(rmv_reg);
                        end
                        default: begin
                        end
                    endcase
                    m_data_next.queue_count = cnt_out(count_next);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_data;
        end
        chk_reg     <= chk_next;
        kept_reg    <= kept_next;
        rmv_reg     <= rmv_next;
        rd_slot_reg <= rd_slot_next;
        wr_slot_reg <= wr_slot_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `RRQ_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH))
    `RRQ_ASSERT_SAME(a_walk_tally, state_reg == ST_WALK, kept_reg + rmv_reg == chk_reg)
    `RRQ_ASSERT_SAME(a_walk_bound, state_reg == ST_WALK, chk_reg <= count_reg)
    `RRQ_ASSERT_NEXT(a_commit_shows, commit, m_valid_reg && (state_reg == ST_IDLE))
    `RRQ_ASSERT_NEXT(a_deq_drops, head_next != head_reg, count_reg == $past(count_reg) - 1'b1)
    `RRQ_ASSERT_NEXT(a_hold_result, m_valid_reg && !m_ready, m_valid_reg && $stable(m_data_reg))

endmodule

`default_nettype wire
